FILE: rtl/set_assoc_cache_tag_directory_unit_macros.svh
// assertion macros for the cache tag directory
// used by the top level only; no other dependencies
`ifndef SET_ASSOC_CACHE_TAG_DIRECTORY_UNIT_MACROS_SVH
`define SET_ASSOC_CACHE_TAG_DIRECTORY_UNIT_MACROS_SVH
`ifndef SYNTH
`define SCTD_ASSERT_SAME(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("sctd same-cycle check failed");
`define SCTD_ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("sctd next-cycle check failed");
`else
`define SCTD_ASSERT_SAME(label, clk, rst_n, a, b)
`define SCTD_ASSERT_NEXT(label, clk, rst_n, a, b)
`endif
`endif

FILE: rtl/sctd_pkg.sv
// shared types, geometry constants and codes for the cache tag directory
// no dependencies
package sctd_pkg;

    localparam int SET_COUNT   = 64;
    localparam int WAY_COUNT   = 8;
    localparam int BLOCK_BYTES = 64;

    localparam int SET_W = $clog2(SET_COUNT);
    localparam int WAY_W = $clog2(WAY_COUNT);
    localparam int OFF_W = $clog2(BLOCK_BYTES);
    localparam int TAG_W = 32 - OFF_W;

    localparam logic [31:0] LFSR_TAPS = 32'h8020_0003;
    localparam logic [31:0] LFSR_SEED = 32'h0000_0001;

    typedef enum logic [2:0] {
        REQ_LOOKUP = 3'd0,
        REQ_READ   = 3'd1,
        REQ_WRITE  = 3'd2,
        REQ_TOUCH  = 3'd3,
        REQ_VICTIM = 3'd4
    } req_code_t;

    typedef enum logic [2:0] {
        ST_N   = 3'd0,
        ST_M   = 3'd1,
        ST_O   = 3'd2,
        ST_E   = 3'd3,
        ST_S   = 3'd4,
        ST_INV = 3'd5
    } coh_state_t;

    typedef enum logic [1:0] {
        MODE_LRU  = 2'd0,
        MODE_FIFO = 2'd1,
        MODE_RAND = 2'd2,
        MODE_ALT  = 2'd3
    } repl_mode_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [31:0] address;
        logic [5:0]  set_index;
        logic [2:0]  way_index;
        logic [31:0] new_tag;
        logic [2:0]  new_state;
    } req_t;

    typedef struct packed {
        logic        hit;
        logic [5:0]  out_set;
        logic [2:0]  out_way;
        logic [31:0] out_tag;
        logic [2:0]  out_state;
        logic [5:0]  byte_offset;
    } rsp_t;

    typedef struct packed {
        logic [WAY_W-1:0] rank;
        logic [2:0]       state;
        logic [TAG_W-1:0] tag;
    } way_entry_t;

    typedef way_entry_t [WAY_COUNT-1:0] row_t;

    typedef struct packed {
        logic accept;
        logic finish;
    } ctl_cmd_t;

    typedef enum logic {
        CTL_IDLE,
        CTL_RUN
    } ctl_state_t;

endpackage

FILE: rtl/sctd_ram.sv
// generic single-write, single-read RAM with registered read data
// no dependencies
module sctd_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

FILE: rtl/sctd_ctrl.sv
// request sequencer: accept, directory read, update and result hand-off
// depends on sctd_pkg
module sctd_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              req_valid,
    output logic              req_ready,
    output logic              rsp_valid,
    input  logic              rsp_ready,
    output sctd_pkg::ctl_cmd_t cmd
);
    import sctd_pkg::*;

    ctl_state_t state_reg, state_next;
    logic       rsp_valid_reg, rsp_valid_next;
    logic       slot_free;

    assign slot_free = !rsp_valid_reg || rsp_ready;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            CTL_IDLE:
            begin
                if (req_valid)
                begin
                    state_next = CTL_RUN;
                end
            end
            CTL_RUN:
            begin
                if (slot_free)
                begin
                    state_next = CTL_IDLE;
                end
            end
            default: state_next = CTL_IDLE;
        endcase
    end

    always_comb
    begin
        req_ready  = 1'b0;
        cmd.accept = 1'b0;
        cmd.finish = 1'b0;
        unique case (state_reg)
            CTL_IDLE:
            begin
                req_ready  = 1'b1;
                cmd.accept = req_valid;
            end
            CTL_RUN:
            begin
                cmd.finish = slot_free;
            end
            default: req_ready = 1'b0;
        endcase
    end

    // result register empties when taken, refills on finish
    always_comb
    begin
        rsp_valid_next = rsp_valid_reg;
        if (cmd.finish)
        begin
            rsp_valid_next = 1'b1;
        end
        else if (rsp_ready)
        begin
            rsp_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= CTL_IDLE;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    assign rsp_valid = rsp_valid_reg;

endmodule

FILE: rtl/sctd_datapath.sv
// directory rows, tag compare, order update, lfsr and result register
// depends on sctd_pkg and sctd_ram
module sctd_datapath (
    input  logic               clk,
    input  logic               rst_n,
    input  sctd_pkg::ctl_cmd_t cmd,
    input  sctd_pkg::req_t     req,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_data,
    output sctd_pkg::rsp_t     rsp
);
    import sctd_pkg::*;

    req_t             req_reg;
    logic [SET_W-1:0] set_reg;
    rsp_t             rsp_reg, rsp_next;
    logic [1:0]       mode_reg;
    logic [31:0]      lfsr_reg, lfsr_next;
    logic [SET_COUNT-1:0] row_vld_reg, row_vld_next;

    logic [SET_W-1:0] rd_set;
    row_t             ram_rdata;
    row_t             cur_row, new_row, reset_row;
    logic [WAY_W-1:0] way_sel;
    logic [TAG_W-1:0] lkey, wkey;
    logic [2:0]       wstate;
    logic             found;
    logic [WAY_W-1:0] hit_way, tail;
    logic             tail_found;
    logic [31:0]      lfsr_adv;

    function automatic row_t promote_to_head(row_t r, logic [WAY_W-1:0] way);
        row_t             res;
        logic [WAY_W-1:0] old;
        res = r;
        old = r[way].rank;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            if (r[w].rank < old)
            begin
                res[w].rank = r[w].rank + 1'b1;
            end
        end
        res[way].rank = '0;
        return res;
    endfunction

    // lookups index by the set bits of the address
    assign rd_set = (req.req_type == REQ_LOOKUP) ? req.address[OFF_W +: SET_W]
                                                 : req.set_index[SET_W-1:0];

    sctd_ram #(
        .WIDTH ($bits(row_t)),
        .DEPTH (SET_COUNT)
    ) u_row_ram (
        .clk   (clk),
        .we    (cmd.finish),
        .waddr (set_reg),
        .wdata (new_row),
        .re    (cmd.accept),
        .raddr (rd_set),
        .rdata (ram_rdata)
    );

    always_comb
    begin
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            reset_row[w].rank  = WAY_W'(w);
            reset_row[w].state = ST_INV;
            reset_row[w].tag   = '0;
        end
    end

    // a row never written reads as its reset contents
    assign cur_row = row_vld_reg[set_reg] ? ram_rdata : reset_row;
    assign way_sel = req_reg.way_index[WAY_W-1:0];
    assign lkey    = req_reg.address[31:OFF_W];
    assign wkey    = req_reg.new_tag[31:OFF_W];
    assign wstate  = (req_reg.new_state > ST_INV) ? ST_INV : req_reg.new_state;

    always_comb
    begin
        found   = 1'b0;
        hit_way = '0;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            if (!found && cur_row[w].tag == lkey && cur_row[w].state != ST_INV)
            begin
                found   = 1'b1;
                hit_way = WAY_W'(w);
            end
        end
    end

    always_comb
    begin
        tail_found = 1'b0;
        tail       = '0;
        for (int w = 0; w < WAY_COUNT; w++)
        begin
            if (!tail_found && cur_row[w].rank == WAY_W'(WAY_COUNT - 1))
            begin
                tail_found = 1'b1;
                tail       = WAY_W'(w);
            end
        end
    end

    // galois step, shift right
    assign lfsr_adv = lfsr_reg[0] ? ((lfsr_reg >> 1) ^ LFSR_TAPS) : (lfsr_reg >> 1);

    always_comb
    begin
        rsp_next  = '0;
        new_row   = cur_row;
        lfsr_next = lfsr_reg;
        case (req_reg.req_type)
            REQ_LOOKUP:
            begin
                rsp_next.out_tag     = {lkey, {OFF_W{1'b0}}};
                rsp_next.byte_offset = 6'(req_reg.address[OFF_W-1:0]);
                rsp_next.out_state   = ST_INV;
                if (found)
                begin
                    rsp_next.hit       = 1'b1;
                    rsp_next.out_set   = 6'(set_reg);
                    rsp_next.out_way   = 3'(hit_way);
                    rsp_next.out_state = cur_row[hit_way].state;
                end
            end
            REQ_READ:
            begin
                rsp_next.out_set   = 6'(set_reg);
                rsp_next.out_way   = 3'(way_sel);
                rsp_next.out_tag   = {cur_row[way_sel].tag, {OFF_W{1'b0}}};
                rsp_next.out_state = cur_row[way_sel].state;
            end
            REQ_WRITE:
            begin
                if (mode_reg == MODE_FIFO && cur_row[way_sel].tag != wkey)
                begin
                    new_row = promote_to_head(cur_row, way_sel);
                end
                new_row[way_sel].tag   = wkey;
                new_row[way_sel].state = wstate;
                rsp_next.out_set = 6'(set_reg);
                rsp_next.out_way = 3'(way_sel);
            end
            REQ_TOUCH:
            begin
                if (mode_reg == MODE_LRU ||
                    (mode_reg == MODE_FIFO && cur_row[way_sel].state == ST_INV))
                begin
                    new_row = promote_to_head(cur_row, way_sel);
                end
                rsp_next.out_set = 6'(set_reg);
                rsp_next.out_way = 3'(way_sel);
            end
            REQ_VICTIM:
            begin
                rsp_next.out_set = 6'(set_reg);
                if (mode_reg == MODE_LRU || mode_reg == MODE_FIFO)
                begin
                    new_row          = promote_to_head(cur_row, tail);
                    rsp_next.out_way = 3'(tail);
                end
                else
                begin
                    lfsr_next        = lfsr_adv;
                    rsp_next.out_way = 3'(lfsr_adv[WAY_W-1:0]);
                end
            end
            default: rsp_next = '0;
        endcase
    end

    always_comb
    begin
        row_vld_next = row_vld_reg;
        if (cmd.finish)
        begin
            row_vld_next[set_reg] = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= MODE_LRU;
            lfsr_reg    <= LFSR_SEED;
            row_vld_reg <= '0;
        end
        else
        begin
            if (cfg_valid)
            begin
                mode_reg <= cfg_data;
            end
            if (cmd.finish)
            begin
                lfsr_reg <= lfsr_next;
            end
            row_vld_reg <= row_vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.accept)
        begin
            req_reg <= req;
            set_reg <= rd_set;
        end
        if (cmd.finish)
        begin
            rsp_reg <= rsp_next;
        end
    end

    assign rsp = rsp_reg;

endmodule

FILE: rtl/set_assoc_cache_tag_directory_unit.sv
// Tag directory of a set-associative cache with LRU, FIFO or random victim choice.
// Channels: req (valid/ready) carries one request transaction, rsp (valid/ready)
// returns exactly one result transaction per request, cfg (valid/ready, always
// ready) writes the replacement mode and should only be used while idle.
// For each request, the accept edge reads the whole set row
// (tags, states and order ranks of all ways) from one RAM, the finish edge
// compares all ways in parallel, writes the updated row back through the
// same RAM's write port and loads the result register. A new request is
// not accepted until the current one has finished.
// A finished result waits in the output register; a new request is still
// accepted while it waits, but that request cannot finish until the result
// is taken, so a stalled receiver holds off the block after one more item.
// Reset: the order ranks, states and tags of every set read as their reset
// values through per-set valid flops, so no clearing pass is needed and
// requests are accepted from the first cycle after reset. LFSR seed is 1,
// replacement mode LRU.
// depends on sctd_pkg, sctd_ctrl, sctd_datapath and the macros header
`include "set_assoc_cache_tag_directory_unit_macros.svh"
module set_assoc_cache_tag_directory_unit (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_ready,
    input  sctd_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_ready,
    output sctd_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_data
);
    import sctd_pkg::*;

    ctl_cmd_t cmd;

    assign cfg_ready = 1'b1;

    sctd_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .cmd       (cmd)
    );

    sctd_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .req       (req),
        .cfg_valid (cfg_valid),
        .cfg_data  (cfg_data),
        .rsp       (rsp)
    );

    `SCTD_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, cmd.accept, !req_ready)
    `SCTD_ASSERT_NEXT(a_result_after_finish, clk, rst_n, cmd.finish, rsp_valid)
    `SCTD_ASSERT_SAME(a_accept_finish_apart, clk, rst_n, cmd.accept, !cmd.finish)

endmodule
